// ===== sv/sgc_pkg.sv =====
package sgc_pkg;

	localparam int FRAME_WIDTH_DEF = 32;
	localparam int IDX_W = 5;
	localparam int COL_W = 8;
	localparam int CNT_W = 3;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_COUNT = 96;
	localparam int GIDX_W = 7;
	localparam int GLYPH_W = COL_W * (GLYPH_COLS + 1);

	localparam logic [COL_W-1:0] FIRST_CODE = 8'h20;
	localparam logic [COL_W-1:0] BLOCK_CODE = 8'h7F;

	typedef struct packed {
		logic             load;
		logic             shift;
		logic             last;
		logic [CNT_W-1:0] col_sel;
		logic             rd_issue;
		logic             rd_emit;
	} cmd_t;

	typedef struct packed {
		logic             out_free;
		logic [CNT_W-1:0] width;
	} sts_t;

	// width byte, then columns 0..4
	localparam logic [GLYPH_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
		48'h03_00_00_00_00_00, 48'h01_FD_00_00_00_00,
		48'h05_E0_C0_00_E0_C0, 48'h05_24_FF_24_FF_24,
		48'h05_12_2A_7F_2A_24, 48'h05_63_64_08_13_63,
		48'h05_76_89_95_62_05, 48'h01_E0_00_00_00_00,
		48'h04_00_3C_42_81_00, 48'h04_00_81_42_3C_00,
		48'h05_22_2C_F0_2C_22, 48'h05_08_08_3E_08_08,
		48'h03_07_1C_10_00_00, 48'h05_08_08_08_08_08,
		48'h02_03_03_00_00_00, 48'h05_03_06_18_60_C0,
		48'h05_7E_89_91_A1_7E, 48'h04_00_41_FF_01_00,
		48'h05_43_85_89_91_61, 48'h05_42_81_91_91_6E,
		48'h05_18_28_48_FF_08, 48'h05_F2_91_91_91_8E,
		48'h05_1E_29_49_89_86, 48'h05_80_8F_90_A0_C0,
		48'h05_6E_91_91_91_6E, 48'h05_70_89_89_8A_7C,
		48'h02_6C_6C_00_00_00, 48'h03_03_6E_68_00_00,
		48'h04_08_14_22_41_00, 48'h05_14_14_14_14_14,
		48'h04_41_22_14_08_00, 48'h05_60_80_8D_90_60,
		48'h05_66_89_8F_81_7E, 48'h05_3F_48_88_48_3F,
		48'h05_FF_91_91_91_6E, 48'h05_7E_81_81_81_42,
		48'h05_FF_81_81_42_3C, 48'h05_FF_91_91_91_81,
		48'h05_FF_90_90_90_80, 48'h05_7E_81_89_89_4E,
		48'h05_FF_10_10_10_FF, 48'h05_81_81_FF_81_81,
		48'h05_06_01_01_01_FE, 48'h05_FF_18_24_42_81,
		48'h05_FF_01_01_01_01, 48'h05_FF_40_30_40_FF,
		48'h05_FF_40_30_08_FF, 48'h05_7E_81_81_81_7E,
		48'h05_FF_88_88_88_70, 48'h05_7E_81_85_82_7D,
		48'h05_FF_88_8C_8A_71, 48'h05_61_91_91_91_8E,
		48'h05_80_80_FF_80_80, 48'h05_FE_01_01_01_FE,
		48'h05_F0_0C_03_0C_F0, 48'h05_FF_02_0C_02_FF,
		48'h05_C3_24_18_24_C3, 48'h05_E0_10_0F_10_E0,
		48'h05_83_85_99_A1_C1, 48'h03_FF_81_81_00_00,
		48'h05_C0_60_18_06_03, 48'h03_81_81_FF_00_00,
		48'h05_20_40_80_40_20, 48'h05_01_01_01_01_01,
		48'h02_C0_70_00_00_00, 48'h05_06_29_29_29_1F,
		48'h05_FF_09_11_11_0E, 48'h05_1E_21_21_21_12,
		48'h05_0E_11_11_09_FF, 48'h05_0E_15_15_15_0C,
		48'h05_08_7F_88_80_40, 48'h05_30_49_49_49_7E,
		48'h05_FF_08_10_10_0F, 48'h01_5F_00_00_00_00,
		48'h04_02_01_21_BE_00, 48'h04_FF_04_0A_11_00,
		48'h04_00_81_FF_01_00, 48'h05_3F_20_18_20_1F,
		48'h05_3F_10_20_20_1F, 48'h05_0E_11_11_11_0E,
		48'h05_3F_24_24_24_18, 48'h05_10_28_28_18_3F,
		48'h05_1F_08_10_10_08, 48'h05_09_15_15_15_02,
		48'h05_20_FE_21_01_02, 48'h05_1E_01_01_02_1F,
		48'h05_1C_02_01_02_1C, 48'h05_1E_01_0E_01_1E,
		48'h05_11_0A_04_0A_11, 48'h05_00_39_05_05_3E,
		48'h05_11_13_15_19_11, 48'h03_10_6E_81_00_00,
		48'h01_FF_00_00_00_00, 48'h03_81_6E_10_00_00,
		48'h04_40_80_40_80_00, 48'h05_FF_FF_FF_FF_FF
	};

endpackage

// ===== sv/sgc_datapath.sv =====
module sgc_datapath import sgc_pkg::*; #(
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [COL_W-1:0] char_code,
	input  logic [IDX_W-1:0] column_index,
	input  logic             result_stall,
	output logic             result_valid,
	output logic [COL_W-1:0] column_bits,
	output logic             last,
	input  cmd_t             cmd,
	output sts_t             sts
);

	localparam int AW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
	localparam int SW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam logic [AW-1:0] HEAD_MAX = AW'(FRAME_WIDTH - 1);
	localparam logic [SW-1:0] FRAME_W_S = SW'(FRAME_WIDTH);

	logic [COL_W-1:0]       mem_q [FRAME_WIDTH];
	logic [FRAME_WIDTH-1:0] vld_q;
	logic [AW-1:0]          head_q;
	logic [GIDX_W-1:0]      gidx_q;
	logic [IDX_W-1:0]       idx_q;
	logic [COL_W-1:0]       rd_data_q;
	logic                   rd_ok_q;
	logic                   result_valid_q;
	logic [COL_W-1:0]       column_bits_q;
	logic                   last_q;

	logic [GIDX_W-1:0]  gidx_d;
	logic [GLYPH_W-1:0] glyph;
	logic [COL_W-1:0]   gwidth_raw;
	logic [CNT_W-1:0]   gwidth;
	logic [COL_W-1:0]   gcol [GLYPH_COLS];
	logic [COL_W-1:0]   shift_col;
	logic [SW-1:0]      sum;
	logic [SW-1:0]      wrapped;
	logic [AW-1:0]      rd_addr;
	logic               in_range;

	always_comb begin
		if (char_code < FIRST_CODE || char_code > BLOCK_CODE) begin
			gidx_d = GIDX_W'(BLOCK_CODE - FIRST_CODE);
		end else begin
			gidx_d = GIDX_W'(char_code - FIRST_CODE);
		end
	end

	always_comb begin
		glyph = GLYPH_ROM[gidx_q];
		gwidth_raw = glyph[GLYPH_W-1 -: COL_W];
		gwidth = (gwidth_raw > COL_W'(GLYPH_COLS)) ? CNT_W'(GLYPH_COLS) : gwidth_raw[CNT_W-1:0];
		for (int i = 0; i < GLYPH_COLS; i++) begin
			gcol[i] = glyph[GLYPH_W-1-COL_W*(i+1) -: COL_W];
		end
		shift_col = (cmd.col_sel < gwidth) ? gcol[cmd.col_sel] : '0;
	end

	always_comb begin
		sum = SW'(head_q) + SW'(idx_q);
		wrapped = (sum >= FRAME_W_S) ? sum - FRAME_W_S : sum;
		rd_addr = wrapped[AW-1:0];
		in_range = SW'(idx_q) < FRAME_W_S;
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			mem_q[head_q] <= shift_col;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (cmd.load) begin
			gidx_q <= gidx_d;
			idx_q <= column_index;
		end
		if (cmd.shift) begin
			column_bits_q <= shift_col;
			last_q <= cmd.last;
		end else if (cmd.rd_emit) begin
			column_bits_q <= rd_ok_q ? rd_data_q : '0;
			last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			head_q <= '0;
			rd_ok_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.shift) begin
				vld_q[head_q] <= 1'b1;
				head_q <= (head_q == HEAD_MAX) ? '0 : head_q + 1'b1;
			end
			if (cmd.rd_issue) begin
				rd_ok_q <= vld_q[rd_addr] && in_range;
			end
			if (cmd.shift || cmd.rd_emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !result_valid_q || !result_stall;
	assign sts.width = gwidth;
	assign result_valid = result_valid_q;
	assign column_bits = column_bits_q;
	assign last = last_q;

endmodule

// ===== sv/sgc_ctrl.sv =====
module sgc_ctrl import sgc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic kind,
	output logic item_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_RDMEM = 2'd2;
	localparam logic [1:0] ST_RDOUT = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] k_d;

	always_comb begin
		cmd = '0;
		cmd.col_sel = k_q;
		state_d = state_q;
		k_d = k_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					k_d = '0;
					state_d = kind ? ST_RDMEM : ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (sts.out_free) begin
					cmd.shift = 1'b1;
					cmd.last = (k_q == sts.width);
					if (k_q == sts.width) begin
						state_d = ST_IDLE;
					end else begin
						k_d = k_q + 1'b1;
					end
				end
			end
			ST_RDMEM: begin
				cmd.rd_issue = 1'b1;
				state_d = ST_RDOUT;
			end
			ST_RDOUT: begin
				if (sts.out_free) begin
					cmd.rd_emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
		end
	end

	assign item_stall = (state_q != ST_IDLE);

`ifndef SYNTHESIS
	a_shift_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift || cmd.rd_emit) |-> sts.out_free)
		else $error("result loaded while output register busy");
	a_count_in_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (k_q <= sts.width))
		else $error("column count ran past glyph width");
	a_read_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && kind) |=> cmd.rd_issue)
		else $error("read word did not issue a frame read");
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && cmd.last) |=> (state_q == ST_IDLE))
		else $error("final shift did not return to idle");
`endif

endmodule

// ===== sv/scrolling_glyph_column_shifter.sv =====
// Scrolls text into a FRAME_WIDTH x 8 LED frame and reads frame columns back.
// Input channel (item_valid/item_stall): kind, char_code, column_index.
//   kind 0 scrolls in one character: a glyph of w columns (1..5) gives w+1
//   result words, the glyph columns then one blank column, last set on the blank.
//   kind 1 returns one frame column with last set; 0 past the frame edge.
// Output channel (result_valid/result_stall): column_bits, last, from a register.
// One item is in work at a time. A character writes one frame column per shift
// through the single memory port; the next item is accepted after its last shift.
// The glyph is registered at accept, and each shift loads the output register.
// A read has three steps: capture, registered memory read, output load.
// The frame is a circular memory with a head pointer; per-entry valid bits
// make unwritten columns read as zero.
// While the receiver stalls, the current result holds and the next shift waits.
// Reset (arst_n low) clears the frame valid bits, the head pointer and both channels.
module scrolling_glyph_column_shifter import sgc_pkg::*; #(
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             kind,
	input  logic [COL_W-1:0] char_code,
	input  logic [IDX_W-1:0] column_index,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [COL_W-1:0] column_bits,
	output logic             last
);

	cmd_t cmd;
	sts_t sts;

	sgc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.kind       (kind),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	sgc_datapath #(
		.FRAME_WIDTH (FRAME_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.column_index (column_index),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.column_bits  (column_bits),
		.last         (last),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// ===== tb/scrolling_glyph_column_shifter_test.sv =====
module scrolling_glyph_column_shifter_test;
	import sgc_pkg::*;

	localparam int FRAME_W = FRAME_WIDTH_DEF;
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// width byte, then five column bytes, bit 7 of each column is row 0
	localparam logic [47:0] FONT [96] = '{
		48'h03_00_00_00_00_00, 48'h01_FD_00_00_00_00, 48'h05_E0_C0_00_E0_C0, 48'h05_24_FF_24_FF_24,
		48'h05_12_2A_7F_2A_24, 48'h05_63_64_08_13_63, 48'h05_76_89_95_62_05, 48'h01_E0_00_00_00_00,
		48'h04_00_3C_42_81_00, 48'h04_00_81_42_3C_00, 48'h05_22_2C_F0_2C_22, 48'h05_08_08_3E_08_08,
		48'h03_07_1C_10_00_00, 48'h05_08_08_08_08_08, 48'h02_03_03_00_00_00, 48'h05_03_06_18_60_C0,
		48'h05_7E_89_91_A1_7E, 48'h04_00_41_FF_01_00, 48'h05_43_85_89_91_61, 48'h05_42_81_91_91_6E,
		48'h05_18_28_48_FF_08, 48'h05_F2_91_91_91_8E, 48'h05_1E_29_49_89_86, 48'h05_80_8F_90_A0_C0,
		48'h05_6E_91_91_91_6E, 48'h05_70_89_89_8A_7C, 48'h02_6C_6C_00_00_00, 48'h03_03_6E_68_00_00,
		48'h04_08_14_22_41_00, 48'h05_14_14_14_14_14, 48'h04_41_22_14_08_00, 48'h05_60_80_8D_90_60,
		48'h05_66_89_8F_81_7E, 48'h05_3F_48_88_48_3F, 48'h05_FF_91_91_91_6E, 48'h05_7E_81_81_81_42,
		48'h05_FF_81_81_42_3C, 48'h05_FF_91_91_91_81, 48'h05_FF_90_90_90_80, 48'h05_7E_81_89_89_4E,
		48'h05_FF_10_10_10_FF, 48'h05_81_81_FF_81_81, 48'h05_06_01_01_01_FE, 48'h05_FF_18_24_42_81,
		48'h05_FF_01_01_01_01, 48'h05_FF_40_30_40_FF, 48'h05_FF_40_30_08_FF, 48'h05_7E_81_81_81_7E,
		48'h05_FF_88_88_88_70, 48'h05_7E_81_85_82_7D, 48'h05_FF_88_8C_8A_71, 48'h05_61_91_91_91_8E,
		48'h05_80_80_FF_80_80, 48'h05_FE_01_01_01_FE, 48'h05_F0_0C_03_0C_F0, 48'h05_FF_02_0C_02_FF,
		48'h05_C3_24_18_24_C3, 48'h05_E0_10_0F_10_E0, 48'h05_83_85_99_A1_C1, 48'h03_FF_81_81_00_00,
		48'h05_C0_60_18_06_03, 48'h03_81_81_FF_00_00, 48'h05_20_40_80_40_20, 48'h05_01_01_01_01_01,
		48'h02_C0_70_00_00_00, 48'h05_06_29_29_29_1F, 48'h05_FF_09_11_11_0E, 48'h05_1E_21_21_21_12,
		48'h05_0E_11_11_09_FF, 48'h05_0E_15_15_15_0C, 48'h05_08_7F_88_80_40, 48'h05_30_49_49_49_7E,
		48'h05_FF_08_10_10_0F, 48'h01_5F_00_00_00_00, 48'h04_02_01_21_BE_00, 48'h04_FF_04_0A_11_00,
		48'h04_00_81_FF_01_00, 48'h05_3F_20_18_20_1F, 48'h05_3F_10_20_20_1F, 48'h05_0E_11_11_11_0E,
		48'h05_3F_24_24_24_18, 48'h05_10_28_28_18_3F, 48'h05_1F_08_10_10_08, 48'h05_09_15_15_15_02,
		48'h05_20_FE_21_01_02, 48'h05_1E_01_01_02_1F, 48'h05_1C_02_01_02_1C, 48'h05_1E_01_0E_01_1E,
		48'h05_11_0A_04_0A_11, 48'h05_00_39_05_05_3E, 48'h05_11_13_15_19_11, 48'h03_10_6E_81_00_00,
		48'h01_FF_00_00_00_00, 48'h03_81_6E_10_00_00, 48'h04_40_80_40_80_00, 48'h05_FF_FF_FF_FF_FF
	};

	typedef struct {
		logic             kind;
		logic [COL_W-1:0] code;
		logic [IDX_W-1:0] idx;
		int unsigned      gap;
		bit               drain;
	} text_word_t;

	typedef struct {
		logic [COL_W-1:0] col_bits;
		logic             is_last;
	} column_word_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	logic             kind = KIND_CHAR;
	logic [COL_W-1:0] char_code = '0;
	logic [IDX_W-1:0] column_index = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	logic [COL_W-1:0] column_bits;
	logic             last;

	text_word_t   text_q[$];
	column_word_t column_q[$];
	logic [COL_W-1:0] frame_image [FRAME_W];
	column_word_t got_word;
	int unsigned  stall_left = 0;
	int unsigned  mismatches = 0;
	bit           tx_calm = 1'b0;
	bit           rx_calm = 1'b0;

	scrolling_glyph_column_shifter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.char_code    (char_code),
		.column_index (column_index),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.column_bits  (column_bits),
		.last         (last)
	);

	always #5 clk = ~clk;

	function automatic void shift_frame(input logic [COL_W-1:0] col);
		for (int j = 0; j < FRAME_W - 1; j++)
			frame_image[j] = frame_image[j + 1];
		frame_image[FRAME_W - 1] = col;
	endfunction

	task automatic predict_columns(input logic k, input logic [COL_W-1:0] code,
			input logic [IDX_W-1:0] idx);
		logic [COL_W-1:0] c;
		logic [47:0]      g;
		int unsigned      w;
		column_word_t     e;
		if (k == KIND_READ) begin
			e.col_bits = (idx < FRAME_W) ? frame_image[idx] : '0;
			e.is_last = 1'b1;
			column_q.push_back(e);
		end else begin
			c = (code < FIRST_CODE || code > BLOCK_CODE) ? BLOCK_CODE : code;
			g = FONT[7'(c - FIRST_CODE)];
			w = 32'(g[47:40]);
			if (w > GLYPH_COLS)
				w = GLYPH_COLS;
			for (int n = 0; n < w; n++) begin
				e.col_bits = g[39 - 8 * n -: 8];
				e.is_last = 1'b0;
				shift_frame(e.col_bits);
				column_q.push_back(e);
			end
			shift_frame('0);
			e.col_bits = '0;
			e.is_last = 1'b1;
			column_q.push_back(e);
		end
	endtask

	task automatic queue_word(input logic k, input logic [COL_W-1:0] code,
			input logic [IDX_W-1:0] idx, input bit drain);
		text_word_t t;
		if ($urandom_range(0, 15) == 0)
			tx_calm = !tx_calm;
		t.kind = k;
		t.code = code;
		t.idx = idx;
		t.gap = tx_calm ? 0 : $urandom_range(0, 10);
		t.drain = drain;
		text_q.push_back(t);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			kind <= KIND_CHAR;
			char_code <= '0;
			column_index <= '0;
		end else begin
			if (item_valid && !item_stall)
				predict_columns(kind, char_code, column_index);
			if (!(item_valid && item_stall)) begin
				if (text_q.size() != 0 && text_q[0].gap != 0) begin
					text_q[0].gap = text_q[0].gap - 1;
					item_valid <= 1'b0;
				end else if (text_q.size() != 0 &&
						!(text_q[0].drain && column_q.size() != 0)) begin
					kind <= text_q[0].kind;
					char_code <= text_q[0].code;
					column_index <= text_q[0].idx;
					item_valid <= 1'b1;
					void'(text_q.pop_front());
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (column_q.size() == 0) begin
					$display("%0t: unexpected word column_bits %02h last %0b",
						$time, column_bits, last);
					mismatches++;
				end else begin
					got_word = column_q.pop_front();
					if (got_word.col_bits !== column_bits) begin
						$display("%0t: column_bits expected %02h actual %02h",
							$time, got_word.col_bits, column_bits);
						mismatches++;
					end
					if (got_word.is_last !== last) begin
						$display("%0t: last expected %0b actual %0b",
							$time, got_word.is_last, last);
						mismatches++;
					end
				end
				if ($urandom_range(0, 19) == 0)
					rx_calm = !rx_calm;
				stall_left = rx_calm ? 0 : $urandom_range(0, 10);
			end
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left = stall_left - 1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		for (int j = 0; j < FRAME_W; j++)
			frame_image[j] = '0;

		queue_word(KIND_READ, 8'h00, 5'd0, 1'b0);
		queue_word(KIND_READ, 8'hFF, 5'd31, 1'b0);
		queue_word(KIND_CHAR, 8'h00, 5'd0, 1'b0);
		queue_word(KIND_CHAR, 8'h1F, 5'd31, 1'b0);
		queue_word(KIND_CHAR, 8'h20, 5'd0, 1'b0);
		queue_word(KIND_CHAR, 8'h21, 5'd0, 1'b0);
		queue_word(KIND_CHAR, 8'h2E, 5'd0, 1'b0);
		queue_word(KIND_CHAR, 8'h2C, 5'd0, 1'b0);
		queue_word(KIND_CHAR, 8'h7E, 5'd0, 1'b0);
		queue_word(KIND_CHAR, 8'h7F, 5'd0, 1'b0);
		queue_word(KIND_CHAR, 8'h80, 5'd0, 1'b0);
		queue_word(KIND_CHAR, 8'hFF, 5'd0, 1'b0);
		queue_word(KIND_CHAR, 8'h41, 5'd0, 1'b0);
		queue_word(KIND_READ, 8'h00, 5'd31, 1'b1);
		queue_word(KIND_READ, 8'h00, 5'd30, 1'b0);
		queue_word(KIND_READ, 8'h00, 5'd0, 1'b0);
		queue_word(KIND_READ, 8'h00, 5'd16, 1'b0);
		queue_word(KIND_READ, 8'h00, 5'd21, 1'b0);
		queue_word(KIND_READ, 8'h00, 5'd10, 1'b0);

		for (int i = 0; i < 151; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5:
					queue_word(KIND_CHAR, 8'($urandom_range(32, 127)),
						5'($urandom_range(0, 31)), (i % 50) == 25);
				6:
					queue_word(KIND_CHAR, 8'($urandom_range(0, 255)),
						5'($urandom_range(0, 31)), (i % 50) == 25);
				default:
					queue_word(KIND_READ, 8'($urandom_range(0, 255)),
						5'($urandom_range(0, 31)), (i % 50) == 25);
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (text_q.size() != 0 || item_valid)
			@(posedge clk);
		while (column_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0 && column_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
